FILE: rtl/core/opt_pkg.sv
package opt_pkg;

   localparam logic [1:0] OP_OBSERVE = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_REPORT  = 2'd2;

   localparam logic [2:0] ST_NEW     = 3'd0;
   localparam logic [2:0] ST_REFRESH = 3'd1;
   localparam logic [2:0] ST_MOVED   = 3'd2;
   localparam logic [2:0] ST_DROPPED = 3'd3;
   localparam logic [2:0] ST_TICK    = 3'd4;
   localparam logic [2:0] ST_SLOT    = 3'd5;

   localparam logic [2:0] CSR_GATE    = 3'd0;
   localparam logic [2:0] CSR_STILL   = 3'd1;
   localparam logic [2:0] CSR_TRIGGER = 3'd2;
   localparam logic [2:0] CSR_CEILING = 3'd3;
   localparam logic [2:0] CSR_AGE     = 3'd4;

   // Squared field radius of 5000 mm.
   localparam logic [29:0] FIELD_SQ = 30'd25000000;
   localparam logic signed [7:0] AGE_STEP = 8'sd2;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
      logic age;
      logic compact;
      logic tick_done;
      logic sort;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic compact_done;
      logic sort_done;
      logic emit_last;
      logic out_free;
   } stat_type;

endpackage

FILE: rtl/core/opt_ctrl.sv
module opt_ctrl import opt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_COMMIT, S_AGE, S_COMPACT, S_TICK_DONE, S_SORT, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               priority if (req_operation == OP_OBSERVE) state_in = S_SCAN;
               else if (req_operation == OP_TICK)        state_in = S_AGE;
               else if (req_operation == OP_REPORT)      state_in = S_SORT;
               else                                      state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_COMMIT;
            else cmd.scan = 1'b1;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_AGE: begin
            cmd.age  = 1'b1;
            state_in = S_COMPACT;
         end
         S_COMPACT: begin
            if (stat.compact_done) state_in = S_TICK_DONE;
            else cmd.compact = 1'b1;
         end
         S_TICK_DONE: begin
            if (stat.out_free) begin
               cmd.tick_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SORT: begin
            if (stat.sort_done) state_in = S_EMIT;
            else cmd.sort = 1'b1;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.emit_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_TICK |=> state_ff == S_AGE)
      else $error("tick did not start aging");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_AGE |=> state_ff == S_COMPACT)
      else $error("aging not followed by compaction");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit, cmd.tick_done, cmd.emit}))
      else $error("two results loaded at once");

endmodule

FILE: rtl/core/opt_datapath.sv
module opt_datapath import opt_pkg::*; #(
   parameter int MAX_TRACKS   = 16,
   parameter int REPORT_SLOTS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic signed [13:0] req_pos_x,
   input  logic signed [13:0] req_pos_y,
   input  logic [13:0]        req_range_mm,
   input  logic [31:0]        req_now_ms,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [2:0]         rsp_slot,
   output logic signed [13:0] rsp_out_x,
   output logic signed [13:0] rsp_out_y,
   output logic [13:0]        rsp_out_range,
   output logic               rsp_slot_valid,
   output logic [4:0]         rsp_removed_count,
   output logic               rsp_last_of_run
);

   localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CW = $clog2(MAX_TRACKS + 1);
   localparam int SW = $clog2(REPORT_SLOTS + 1);

   // Configuration registers.
   logic [12:0] gate_ff, still_ff;
   logic [6:0]  trig_ff, ceil_ff;
   logic [15:0] age_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff  <= 13'd300;
         still_ff <= 13'd50;
         trig_ff  <= 7'd3;
         ceil_ff  <= 7'd10;
         age_ff   <= 16'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GATE:    gate_ff  <= csr_data[12:0];
            CSR_STILL:   still_ff <= csr_data[12:0];
            CSR_TRIGGER: trig_ff  <= csr_data[6:0];
            CSR_CEILING: ceil_ff  <= csr_data[6:0];
            CSR_AGE:     age_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Track table.
   logic signed [13:0] x_ff [MAX_TRACKS];
   logic signed [13:0] x_in [MAX_TRACKS];
   logic signed [13:0] y_ff [MAX_TRACKS];
   logic signed [13:0] y_in [MAX_TRACKS];
   logic [13:0]        r_ff [MAX_TRACKS];
   logic [13:0]        r_in [MAX_TRACKS];
   logic signed [7:0]  c_ff [MAX_TRACKS];
   logic signed [7:0]  c_in [MAX_TRACKS];
   logic [31:0]        t_ff [MAX_TRACKS];
   logic [31:0]        t_in [MAX_TRACKS];
   logic [CW-1:0]      cnt_ff, cnt_in;

   // Latched word and derived thresholds.
   logic signed [13:0] px_ff, py_ff;
   logic [13:0]        pr_ff;
   logic [31:0]        now_ff;
   logic [25:0]        gate2_ff, still2_ff;

   // Nearest-match scan.
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               p1_v_ff, p2_v_ff;
   logic [IW-1:0]      p1_idx_ff, p2_idx_ff;
   logic signed [14:0] dx_ff, dy_ff;
   logic signed [29:0] sqx_ff, sqy_ff;
   logic [29:0]        best_ff, best_in;
   logic [IW-1:0]      hit_ff, hit_in;
   logic               found_ff, found_in;
   logic [IW-1:0]      si;
   logic               issue;
   logic [29:0]        d2;

   // Compaction, sort and report sequencing.
   logic [CW-1:0]      rd_ff, rd_in, wr_ff, wr_in;
   logic [4:0]         removed_ff, removed_in;
   logic [CW-1:0]      ph_ff, ph_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [IW-1:0]      rdi, wri, ai, ei;
   logic               emit_hit;

   assign si    = IW'(scan_idx_ff);
   assign issue = cmd.scan && (scan_idx_ff < cnt_ff);
   assign d2    = 30'(sqx_ff) + 30'(sqy_ff);
   assign rdi   = IW'(rd_ff);
   assign wri   = IW'(wr_ff);
   assign ai    = IW'(cnt_ff);
   assign ei    = IW'(slot_ff);
   assign emit_hit = (int'(slot_ff) < int'(cnt_ff)) &&
                     (c_ff[ei] > $signed({1'b0, trig_ff}));

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      r_in = r_ff;
      c_in = c_ff;
      t_in = t_ff;
      cnt_in = cnt_ff;
      if (cmd.commit) begin
         if (found_ff) begin
            t_in[hit_ff] = now_ff;
            if (c_ff[hit_ff] < $signed({1'b0, ceil_ff})) c_in[hit_ff] = c_ff[hit_ff] + 8'sd1;
            if (!(best_ff < 30'(still2_ff))) begin
               x_in[hit_ff] = px_ff;
               y_in[hit_ff] = py_ff;
               r_in[hit_ff] = pr_ff;
            end
         end else if (cnt_ff < CW'(MAX_TRACKS)) begin
            x_in[ai] = px_ff;
            y_in[ai] = py_ff;
            r_in[ai] = pr_ff;
            c_in[ai] = 8'sd1;
            t_in[ai] = now_ff;
            cnt_in   = cnt_ff + CW'(1);
         end
      end
      if (cmd.age) begin
         for (int i = 0; i < MAX_TRACKS; i++) begin
            if (CW'(i) < cnt_ff && (now_ff - t_ff[i]) > {16'd0, age_ff} &&
                c_ff[i] >= 8'sd0) begin
               c_in[i] = c_ff[i] - AGE_STEP;
               t_in[i] = now_ff;
            end
         end
      end
      if (cmd.compact && c_ff[rdi] >= 8'sd0 && wr_ff != rd_ff) begin
         x_in[wri] = x_ff[rdi];
         y_in[wri] = y_ff[rdi];
         r_in[wri] = r_ff[rdi];
         c_in[wri] = c_ff[rdi];
         t_in[wri] = t_ff[rdi];
      end
      if (cmd.tick_done) cnt_in = wr_ff;
      // Odd-even transposition: each phase swaps disjoint neighbor pairs,
      // strictly greater only, so equal ranges keep their order.
      if (cmd.sort) begin
         for (int k = 0; k < MAX_TRACKS - 1; k++) begin
            if (k[0] == ph_ff[0] && CW'(k + 1) < cnt_ff && r_ff[k] > r_ff[k + 1]) begin
               x_in[k] = x_ff[k + 1];  x_in[k + 1] = x_ff[k];
               y_in[k] = y_ff[k + 1];  y_in[k + 1] = y_ff[k];
               r_in[k] = r_ff[k + 1];  r_in[k + 1] = r_ff[k];
               c_in[k] = c_ff[k + 1];  c_in[k + 1] = c_ff[k];
               t_in[k] = t_ff[k + 1];  t_in[k + 1] = t_ff[k];
            end
         end
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      best_in     = best_ff;
      hit_in      = hit_ff;
      found_in    = found_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      removed_in  = removed_ff;
      ph_in       = ph_ff;
      slot_in     = slot_ff;
      if (cmd.load) begin
         scan_idx_in = '0;
         best_in     = FIELD_SQ;
         found_in    = 1'b0;
         hit_in      = '0;
         ph_in       = '0;
         slot_in     = '0;
      end
      if (issue) scan_idx_in = scan_idx_ff + CW'(1);
      if (p2_v_ff && d2 < 30'(gate2_ff) && d2 < best_ff) begin
         best_in  = d2;
         hit_in   = p2_idx_ff;
         found_in = 1'b1;
      end
      if (cmd.age) begin
         rd_in      = '0;
         wr_in      = '0;
         removed_in = '0;
      end
      if (cmd.compact) begin
         rd_in = rd_ff + CW'(1);
         if (c_ff[rdi] >= 8'sd0) wr_in = wr_ff + CW'(1);
         else removed_in = removed_ff + 5'd1;
      end
      if (cmd.sort) ph_in = ph_ff + CW'(1);
      if (cmd.emit) slot_in = slot_ff + SW'(1);
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
      c_ff <= c_in;
      t_ff <= t_in;
      scan_idx_ff <= scan_idx_in;
      best_ff  <= best_in;
      hit_ff   <= hit_in;
      found_ff <= found_in;
      removed_ff <= removed_in;
      ph_ff    <= ph_in;
      slot_ff  <= slot_in;
      p1_idx_ff <= si;
      dx_ff    <= {px_ff[13], px_ff} - {x_ff[si][13], x_ff[si]};
      dy_ff    <= {py_ff[13], py_ff} - {y_ff[si][13], y_ff[si]};
      p2_idx_ff <= p1_idx_ff;
      sqx_ff   <= dx_ff * dx_ff;
      sqy_ff   <= dy_ff * dy_ff;
      if (cmd.load) begin
         px_ff     <= req_pos_x;
         py_ff     <= req_pos_y;
         pr_ff     <= req_range_mm;
         now_ff    <= req_now_ms;
         gate2_ff  <= gate_ff * gate_ff;
         still2_ff <= still_ff * still_ff;
      end
      if (reset) begin
         cnt_ff  <= '0;
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         rd_ff   <= '0;
         wr_ff   <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         p1_v_ff <= issue;
         p2_v_ff <= p1_v_ff;
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
      end
   end

   assign stat.scan_done    = (scan_idx_ff >= cnt_ff) && !p1_v_ff && !p2_v_ff;
   assign stat.compact_done = (rd_ff >= cnt_ff);
   assign stat.sort_done    = (ph_ff >= CW'(MAX_TRACKS));
   assign stat.emit_last    = (slot_ff == SW'(REPORT_SLOTS - 1));
   assign stat.out_free     = !rsp_valid || rsp_ready;

   // Result word register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] status_ff, status_in;

   assign rsp_valid_in = cmd.commit || cmd.tick_done || cmd.emit ||
                         (rsp_valid_ff && !rsp_ready);

   always_comb begin
      priority if (found_ff && best_ff < 30'(still2_ff)) status_in = ST_REFRESH;
      else if (found_ff)                              status_in = ST_MOVED;
      else if (cnt_ff < CW'(MAX_TRACKS))              status_in = ST_NEW;
      else                                            status_in = ST_DROPPED;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (cmd.commit || cmd.tick_done || cmd.emit) begin
         status_ff         <= cmd.emit ? ST_SLOT : (cmd.tick_done ? ST_TICK : status_in);
         rsp_slot          <= cmd.emit ? 3'(slot_ff) : 3'd0;
         rsp_out_x         <= (cmd.emit && emit_hit) ? x_ff[ei] : 14'sd0;
         rsp_out_y         <= (cmd.emit && emit_hit) ? y_ff[ei] : 14'sd0;
         rsp_out_range     <= (cmd.emit && emit_hit) ? r_ff[ei] : 14'd0;
         rsp_slot_valid    <= cmd.emit && emit_hit;
         rsp_removed_count <= cmd.tick_done ? removed_ff : 5'd0;
         rsp_last_of_run   <= !cmd.emit || stat.emit_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(MAX_TRACKS))
      else $error("track count beyond table size");
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !found_ff && cnt_ff < CW'(MAX_TRACKS) |=> cnt_ff == $past(cnt_ff) + CW'(1))
      else $error("new track not appended");
   assert property (@(posedge clock) disable iff (reset) wr_ff <= rd_ff)
      else $error("compaction write pointer passed read pointer");
   assert property (@(posedge clock) disable iff (reset)
      cmd.tick_done |=> cnt_ff <= $past(cnt_ff))
      else $error("tick grew the table");

endmodule

FILE: rtl/core/obstacle_point_tracker_unit.sv
// Tracks up to MAX_TRACKS lidar points. An observe word walks the table through a
// three-stage distance pipeline, one entry a cycle. A tick word ages all entries
// at once, then compacts the table one entry a cycle. A report word runs
// MAX_TRACKS phases of an odd-even range sort and then delivers REPORT_SLOTS
// words, one a cycle while the output register is free. One word is worked on
// at a time; a finished result waits in the output register while the next word
// is accepted. Configuration is taken at any time, one write a cycle, and is
// meant to be written while the unit is idle.
module obstacle_point_tracker_unit import opt_pkg::*; #(
   parameter int MAX_TRACKS   = 16,
   parameter int REPORT_SLOTS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [13:0] req_pos_x,
   input  logic signed [13:0] req_pos_y,
   input  logic [13:0]        req_range_mm,
   input  logic [31:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [2:0]         rsp_slot,
   output logic signed [13:0] rsp_out_x,
   output logic signed [13:0] rsp_out_y,
   output logic [13:0]        rsp_out_range,
   output logic               rsp_slot_valid,
   output logic [4:0]         rsp_removed_count,
   output logic               rsp_last_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   cmd_type  cmd;
   stat_type stat;

   opt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .stat, .cmd
   );

   opt_datapath #(.MAX_TRACKS(MAX_TRACKS), .REPORT_SLOTS(REPORT_SLOTS)) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_pos_x, .req_pos_y, .req_range_mm, .req_now_ms,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_slot, .rsp_out_x, .rsp_out_y,
      .rsp_out_range, .rsp_slot_valid, .rsp_removed_count, .rsp_last_of_run
   );

endmodule
